@@ rtl/bsba_pkg.sv @@
// Package for the baseline subtraction block averager: widths, codes, and shared types.
package bsba_pkg;

  localparam int CH_W     = 6;
  localparam int CHANNELS = 1 << CH_W;
  localparam int RAW_W    = 16;
  localparam int CODE_W   = 12;
  localparam int VOLT_W   = 23;
  localparam int AVG_W    = 24;
  localparam int BASE_W   = 24;
  localparam int ACC_W    = 32;
  localparam int CFG_A_W  = 2;
  localparam int CFG_D_W  = 8;
  localparam int FC_W     = 9;
  localparam int DIV_CNT_W = $clog2(ACC_W);

  localparam logic [CFG_A_W-1:0] CFG_INPUT_RANGE    = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_BASELINE_FRAME = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_AVERAGE_LENGTH = 2'd2;

  localparam logic [1:0] RANGE_BIPOLAR_10 = 2'd0;
  localparam logic [1:0] RANGE_BIPOLAR_5  = 2'd1;
  localparam logic [1:0] RANGE_UNIPOLAR_10 = 2'd2;

  localparam logic [CODE_W-1:0] CODE_FLIP = 12'h800;

  typedef struct packed {
    logic [1:0]         input_range;
    logic [CFG_D_W-1:0] baseline_frame;
    logic [CFG_D_W-1:0] average_length;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic read;
    logic sum;
    logic div_start;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic avg;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

@@ rtl/bsba_if.sv @@
// Handshake interfaces for the sample, result and configuration channels.
interface bsba_in_if;
  import bsba_pkg::*;
  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   channel;
  logic [RAW_W-1:0]  raw_code;
  logic              frame_end;
  modport source (output valid, output channel, output raw_code, output frame_end,
                  input ready);
  modport sink   (input valid, input channel, input raw_code, input frame_end,
                  output ready);
endinterface

interface bsba_out_if;
  import bsba_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CH_W-1:0]          out_channel;
  logic signed [VOLT_W-1:0] voltage;
  logic                     average_valid;
  logic signed [AVG_W-1:0]  average;
  modport source (output valid, output out_channel, output voltage,
                  output average_valid, output average, input ready);
  modport sink   (input valid, input out_channel, input voltage,
                  input average_valid, input average, output ready);
endinterface

interface bsba_cfg_if;
  import bsba_pkg::*;
  logic               valid;
  logic               ready;
  logic [CFG_A_W-1:0] addr;
  logic [CFG_D_W-1:0] data;
  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

@@ rtl/bsba_ctrl.sv @@
// Controller state machine sequencing read, sum, divide and result load for one item.
module bsba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bsba_pkg::status_t status_i,
  output bsba_pkg::cmd_t    cmd_o
);
  import bsba_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_PREP = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = status_i.avg ? ST_PREP : ST_DONE;
      end
      ST_PREP: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/bsba_dp.sv @@
// Datapath: conversion, per-channel stores, saturating sum, serial divider and result register.
module bsba_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bsba_pkg::cfg_t    cfg_i,
  input  bsba_pkg::cmd_t    cmd_i,
  output bsba_pkg::status_t status_o,
  input  logic [bsba_pkg::CH_W-1:0]  channel_i,
  input  logic [bsba_pkg::RAW_W-1:0] raw_code_i,
  input  logic                       frame_end_i,
  bsba_out_if.source                 out_o
);
  import bsba_pkg::*;

  localparam logic signed [ACC_W+1:0] ACC_MAX = 34'sd2147483647;
  localparam logic signed [ACC_W+1:0] ACC_MIN = -34'sd2147483648;
  localparam logic [ACC_W-1:0] AVG_POS_LIM = 32'd8388607;
  localparam logic [ACC_W-1:0] AVG_NEG_LIM = 32'd8388608;
  localparam logic signed [AVG_W-1:0] AVG_MAX = 24'sh7FFFFF;
  localparam logic signed [AVG_W-1:0] AVG_MIN = -24'sh800000;

  logic [BASE_W-1:0] base_mem [CHANNELS];
  logic [ACC_W-1:0]  acc_mem  [CHANNELS];
  logic [CHANNELS-1:0] acc_vld_q;

  logic [FC_W-1:0]    fc_q;
  logic [CFG_D_W-1:0] phase_q;

  logic [CH_W-1:0]   ch_q;
  logic [CODE_W-1:0] code_q;
  logic              frame_end_q;
  logic              is_base_q, is_acc_q, is_avg_q;

  logic signed [BASE_W-1:0] v_q;
  logic [BASE_W-1:0]        base_rd_q;
  logic [ACC_W-1:0]         acc_rd_q;
  logic signed [ACC_W-1:0]  s_q;
  logic                     neg_q;
  logic [CFG_D_W-1:0]       rem_q;
  logic [ACC_W-1:0]         dq_q;
  logic [DIV_CNT_W-1:0]     div_cnt_q;

  logic                     out_valid_q;
  logic [CH_W-1:0]          out_ch_q;
  logic signed [VOLT_W-1:0] out_volt_q;
  logic                     out_avg_vld_q;
  logic signed [AVG_W-1:0]  out_avg_q;

  logic [CFG_D_W-1:0] len;
  logic               is_base_d, is_acc_d, is_avg_d;
  logic [10:0]        scale;
  logic signed [BASE_W-1:0] offset;
  logic [VOLT_W-1:0]  prod;
  logic signed [BASE_W-1:0] v_d;
  logic signed [ACC_W-1:0]  acc_val;
  logic signed [ACC_W+1:0]  sum_w;
  logic signed [ACC_W-1:0]  s_d;
  logic [CFG_D_W:0]   trial;
  logic               qbit;
  logic [CFG_D_W-1:0] rem_d;
  logic signed [AVG_W-1:0] avg_d;
  logic [CFG_D_W:0]   phase_inc;
  logic               out_free;

  assign len = (cfg_i.average_length == '0) ? CFG_D_W'(1) : cfg_i.average_length;

  assign is_base_d = (fc_q == {1'b0, cfg_i.baseline_frame});
  assign is_acc_d  = (fc_q > {1'b0, cfg_i.baseline_frame});
  assign is_avg_d  = is_acc_d && (fc_q != '0) && (phase_q == '0);

  always_comb begin
    case (cfg_i.input_range)
      RANGE_BIPOLAR_5: begin
        scale  = 11'd625;
        offset = 24'sd1280000;
      end
      RANGE_UNIPOLAR_10: begin
        scale  = 11'd625;
        offset = 24'sd0;
      end
      default: begin
        scale  = 11'd1250;
        offset = 24'sd2560000;
      end
    endcase
  end

  assign prod = VOLT_W'({11'b0, code_q} * {12'b0, scale});
  assign v_d  = $signed({1'b0, prod}) - offset;

  assign acc_val = acc_vld_q[ch_q] ? $signed(acc_rd_q) : '0;
  assign sum_w   = 34'(acc_val) + 34'(v_q) - 34'($signed(base_rd_q));

  always_comb begin
    if (sum_w > ACC_MAX) begin
      s_d = ACC_MAX[ACC_W-1:0];
    end else if (sum_w < ACC_MIN) begin
      s_d = ACC_MIN[ACC_W-1:0];
    end else begin
      s_d = sum_w[ACC_W-1:0];
    end
  end

  assign trial = {rem_q, dq_q[ACC_W-1]};
  assign qbit  = (trial >= {1'b0, len});
  assign rem_d = qbit ? CFG_D_W'(trial - {1'b0, len}) : trial[CFG_D_W-1:0];

  always_comb begin
    if (!is_avg_q) begin
      avg_d = '0;
    end else if (neg_q) begin
      avg_d = (dq_q > AVG_NEG_LIM) ? AVG_MIN : AVG_W'(-$signed(dq_q));
    end else begin
      avg_d = (dq_q > AVG_POS_LIM) ? AVG_MAX : AVG_W'(dq_q);
    end
  end

  assign phase_inc = {1'b0, phase_q} + 9'd1;
  assign out_free  = !out_valid_q || out_o.ready;

  assign status_o.avg      = is_avg_q;
  assign status_o.div_last = (div_cnt_q == DIV_CNT_W'(ACC_W - 1));
  assign status_o.out_free = out_free;

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      base_rd_q <= base_mem[ch_q];
      acc_rd_q  <= acc_mem[ch_q];
    end
    if (cmd_i.finish && is_base_q) begin
      base_mem[ch_q] <= v_q;
    end
    if (cmd_i.finish && is_acc_q) begin
      acc_mem[ch_q] <= is_avg_q ? '0 : s_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ch_q        <= channel_i;
      code_q      <= (raw_code_i[CODE_W-1:0] ^ CODE_FLIP);
      frame_end_q <= frame_end_i;
      is_base_q   <= is_base_d;
      is_acc_q    <= is_acc_d;
      is_avg_q    <= is_avg_d;
    end
    if (cmd_i.read) begin
      v_q <= v_d;
    end
    if (cmd_i.sum) begin
      s_q <= s_d;
    end
    if (cmd_i.div_start) begin
      neg_q <= s_q[ACC_W-1];
      rem_q <= '0;
      dq_q  <= s_q[ACC_W-1] ? ACC_W'(-s_q) : s_q;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      dq_q  <= {dq_q[ACC_W-2:0], qbit};
    end
    if (cmd_i.finish) begin
      out_ch_q      <= ch_q;
      out_volt_q    <= VOLT_W'(v_q);
      out_avg_vld_q <= is_avg_q;
      out_avg_q     <= avg_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_q   <= '0;
      fc_q        <= '0;
      phase_q     <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.div_start) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        if (is_acc_q) begin
          acc_vld_q[ch_q] <= 1'b1;
        end
        if (frame_end_q) begin
          if (fc_q <= {1'b0, cfg_i.baseline_frame}) begin
            fc_q <= fc_q + FC_W'(1);
          end
          phase_q <= (phase_inc >= {1'b0, len}) ? '0 : phase_inc[CFG_D_W-1:0];
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_channel   = out_ch_q;
  assign out_o.voltage       = out_volt_q;
  assign out_o.average_valid = out_avg_vld_q;
  assign out_o.average       = out_avg_q;

`ifndef SYNTHESIS
  a_step_only_avg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> is_avg_q)
    else $error("divider stepping for an item without an average");
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> out_free)
    else $error("result loaded over an untaken result");
  a_valid_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.finish))
    else $error("result valid without a finished item");
  a_avg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_avg_vld_q) |-> (out_avg_q == '0))
    else $error("nonzero average without average_valid");
`endif

endmodule

@@ rtl/baseline_subtract_block_average.sv @@
// Top level: configuration registers, controller and datapath of the baseline subtractor.
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    channel, raw_code, frame_end
//   out_o    out  valid/ready    out_channel, voltage, average_valid, average
//   cfg_i    in   valid/ready    addr (register index), data
//
// An item with no completed average goes from accept through read and sum to the result
// load; when an average completes, the 32-step restoring divider runs before the load.
// One item is in work at a time; in_i.ready is high only while the controller waits.
// A result waits in the output register while the next item is already being worked.
// Reset clears the accumulator valid bits, frame count and phase; no clearing pass is run.
// cfg_i.ready is always high.
module baseline_subtract_block_average (
  input  logic       clk_i,
  input  logic       rst_ni,
  bsba_in_if.sink    in_i,
  bsba_out_if.source out_o,
  bsba_cfg_if.sink   cfg_i
);
  import bsba_pkg::*;

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.input_range    <= RANGE_BIPOLAR_10;
      cfg_q.baseline_frame <= 8'd2;
      cfg_q.average_length <= 8'd20;
    end else if (cfg_i.valid) begin
      case (cfg_i.addr)
        CFG_INPUT_RANGE:    cfg_q.input_range    <= cfg_i.data[1:0];
        CFG_BASELINE_FRAME: cfg_q.baseline_frame <= cfg_i.data;
        CFG_AVERAGE_LENGTH: cfg_q.average_length <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  assign in_i.ready = in_ready;

  bsba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bsba_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .status_o    (status),
    .channel_i   (in_i.channel),
    .raw_code_i  (in_i.raw_code),
    .frame_end_i (in_i.frame_end),
    .out_o       (out_o)
  );

endmodule
